### hw/rtl/aqils_pkg.sv
package aqils_pkg;

	// Field and register widths.
	localparam int INDEX_WIDTH    = 10;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int HUE_W          = 16;
	localparam int BYTE_W         = 8;
	localparam int GAIN_W         = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_HUE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUL_HUE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DAY_VALUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_VAL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_TARGET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd5;

	// Register reset values.
	localparam logic [HUE_W-1:0]  RST_CLEAN_HUE  = 16'd21500;
	localparam logic [HUE_W-1:0]  RST_FOUL_HUE   = 16'd60000;
	localparam logic [BYTE_W-1:0] RST_DAY_VALUE  = 8'd50;
	localparam logic [BYTE_W-1:0] RST_NIGHT_VAL  = 8'd3;
	localparam logic [BYTE_W-1:0] RST_SAT_TARGET = 8'd255;
	localparam logic [GAIN_W-1:0] RST_GAIN       = 16'd1966;

	// Index clamp window.
	localparam int IDX_LO = 50;
	localparam int IDX_HI = 300;

	// Shared multiplier.
	localparam int MUL_W  = 24;
	localparam int PROD_W = 2 * MUL_W;

	// x = (d << 16) / 250 = (d << 15) / 125, done as a multiply by
	// ceil(2^30 / 125) and a shift by 30. Exact for every d in 0..250.
	localparam int                RECIP_SHIFT = 30;
	localparam logic [MUL_W-1:0]  RECIP_M     = 24'd8589935;

	// Square root: 34-bit radicand, 17-bit root, one root bit per step.
	localparam int RAD_W   = 34;
	localparam int ROOT_W  = 17;
	localparam int REM_W   = 19;
	localparam int SQ_CNT_W = 5;
	localparam logic [SQ_CNT_W-1:0] SQ_LAST = 5'(ROOT_W - 1);

	// Multiplier operand selection codes.
	localparam logic [2:0] MUL_NONE  = 3'd0;
	localparam logic [2:0] MUL_RECIP = 3'd1;
	localparam logic [2:0] MUL_SQR   = 3'd2;
	localparam logic [2:0] MUL_DROP  = 3'd3;
	localparam logic [2:0] MUL_HUE   = 3'd4;
	localparam logic [2:0] MUL_SAT   = 3'd5;
	localparam logic [2:0] MUL_VAL   = 3'd6;

	typedef struct packed {
		logic [HUE_W-1:0]  clean_hue;
		logic [HUE_W-1:0]  foul_hue;
		logic [BYTE_W-1:0] day_value;
		logic [BYTE_W-1:0] night_value;
		logic [BYTE_W-1:0] sat_target;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mul_sel;
		logic       ld_in;
		logic       sqrt_ld;
		logic       sqrt_step;
		logic       upd_hue;
		logic       upd_sat;
		logic       upd_val;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_ready;
	} stat_t;

endpackage

### hw/rtl/aqils_in_if.sv
interface aqils_in_if;
	logic                             valid;
	logic                             ready;
	logic [aqils_pkg::INDEX_WIDTH-1:0] air_index;
	logic                             night;

	modport source (output valid, output air_index, output night, input ready);
	modport sink   (input valid, input air_index, input night, output ready);
endinterface

### hw/rtl/aqils_out_if.sv
interface aqils_out_if;
	logic                         valid;
	logic                         ready;
	logic [aqils_pkg::HUE_W-1:0]  hue_out;
	logic [aqils_pkg::BYTE_W-1:0] sat_out;
	logic [aqils_pkg::BYTE_W-1:0] val_out;

	modport source (output valid, output hue_out, output sat_out, output val_out,
		input ready);
	modport sink   (input valid, input hue_out, input sat_out, input val_out,
		output ready);
endinterface

### hw/rtl/aqils_ctrl.sv
module aqils_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  aqils_pkg::stat_t stat,
	output aqils_pkg::cmd_t  cmd,
	output logic             in_ready,
	output logic             out_valid
);
	import aqils_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RECIP = 4'd1;
	localparam logic [3:0] ST_SQR   = 4'd2;
	localparam logic [3:0] ST_SQLD  = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_DROP  = 4'd5;
	localparam logic [3:0] ST_HUE   = 4'd6;
	localparam logic [3:0] ST_SAT   = 4'd7;
	localparam logic [3:0] ST_VAL   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0]          state_q, state_d;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                out_valid_q;
	logic                out_free;

	// The output register can take a new word when empty or being drained.
	assign out_free  = !out_valid_q || stat.out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_RECIP;
				end
			end
			ST_RECIP: begin
				cmd.mul_sel = MUL_RECIP;
				state_d     = ST_SQR;
			end
			ST_SQR: begin
				cmd.mul_sel = MUL_SQR;
				state_d     = ST_SQLD;
			end
			ST_SQLD: begin
				cmd.sqrt_ld = 1'b1;
				state_d     = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == SQ_LAST) begin
					state_d = ST_DROP;
				end
			end
			ST_DROP: begin
				cmd.mul_sel = MUL_DROP;
				state_d     = ST_HUE;
			end
			ST_HUE: begin
				cmd.mul_sel = MUL_HUE;
				state_d     = ST_SAT;
			end
			ST_SAT: begin
				cmd.upd_hue = 1'b1;
				cmd.mul_sel = MUL_SAT;
				state_d     = ST_VAL;
			end
			ST_VAL: begin
				cmd.upd_sat = 1'b1;
				cmd.mul_sel = MUL_VAL;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				cmd.upd_val = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sqrt_ld) begin
				cnt_q <= '0;
			end else if (cmd.sqrt_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (stat.out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/aqils_dp.sv
module aqils_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  aqils_pkg::cmd_t                     cmd,
	input  aqils_pkg::cfg_t                     cfg,
	input  logic [aqils_pkg::INDEX_WIDTH-1:0]   air_index,
	input  logic                                night,
	output logic [aqils_pkg::HUE_W-1:0]         hue_out,
	output logic [aqils_pkg::BYTE_W-1:0]        sat_out,
	output logic [aqils_pkg::BYTE_W-1:0]        val_out
);
	import aqils_pkg::*;

	logic [BYTE_W-1:0] d_q;
	logic              night_q;
	logic [PROD_W-1:0] p_q;
	logic [MUL_W-1:0]  op_a, op_b;
	logic              sign_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [HUE_W-1:0]  hue_now_q, sat_now_q, val_now_q;
	logic [HUE_W-1:0]  hue_q;
	logic [BYTE_W-1:0] sat_q, val_q;

	logic [INDEX_WIDTH-1:0] idx_c;
	logic [ROOT_W-1:0]      x;
	logic [HUE_W-1:0]       hue_range, drop, hue_set, stp;
	logic [HUE_W:0]         dif;
	logic [HUE_W-1:0]       mag;
	logic [BYTE_W-1:0]      val_tgt;
	logic [REM_W+1:0]       rem_sh, trial;

	// Clamp the index to the working window.
	always_comb begin
		idx_c = air_index;
		if (air_index < INDEX_WIDTH'(IDX_LO)) begin
			idx_c = INDEX_WIDTH'(IDX_LO);
		end else if (air_index > INDEX_WIDTH'(IDX_HI)) begin
			idx_c = INDEX_WIDTH'(IDX_HI);
		end
	end

	assign x         = p_q[RECIP_SHIFT +: ROOT_W];
	assign hue_range = cfg.clean_hue - cfg.foul_hue;
	assign drop      = p_q[HUE_W +: HUE_W];
	assign hue_set   = cfg.clean_hue - drop;
	assign stp       = p_q[GAIN_FRAC_BITS +: HUE_W];
	assign val_tgt   = night_q ? cfg.night_value : cfg.day_value;

	// Signed distance to the target of whichever channel is being stepped.
	always_comb begin
		case (cmd.mul_sel)
			MUL_HUE: dif = {1'b0, hue_set - cfg.foul_hue}
				- {1'b0, hue_now_q - cfg.foul_hue};
			MUL_SAT: dif = {1'b0, cfg.sat_target, 8'd0} - {1'b0, sat_now_q};
			MUL_VAL: dif = {1'b0, val_tgt, 8'd0} - {1'b0, val_now_q};
			default: dif = '0;
		endcase
		mag = dif[HUE_W] ? HUE_W'(-dif) : dif[HUE_W-1:0];
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_RECIP: begin
				op_a = MUL_W'({d_q, 15'd0});
				op_b = RECIP_M;
			end
			MUL_SQR: begin
				op_a = MUL_W'(x);
				op_b = MUL_W'(18'h20000 - {1'b0, x});
			end
			MUL_DROP: begin
				op_a = MUL_W'(hue_range);
				op_b = MUL_W'(root_q);
			end
			MUL_HUE, MUL_SAT, MUL_VAL: begin
				op_a = MUL_W'(mag);
				op_b = MUL_W'(cfg.gain);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// One root bit per step of the digit-by-digit square root.
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = (REM_W+2)'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		p_q <= op_a * op_b;
		if (cmd.ld_in) begin
			d_q     <= BYTE_W'(idx_c - INDEX_WIDTH'(IDX_LO));
			night_q <= night;
		end
		if (cmd.mul_sel == MUL_HUE || cmd.mul_sel == MUL_SAT || cmd.mul_sel == MUL_VAL) begin
			sign_q <= dif[HUE_W];
		end
		if (cmd.sqrt_ld) begin
			rad_q  <= {1'b0, p_q[RAD_W-2:0]};
			root_q <= '0;
			rem_q  <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.out_ld) begin
			hue_q <= hue_now_q;
			sat_q <= sat_now_q[HUE_W-1 -: BYTE_W];
			val_q <= val_now_q[HUE_W-1 -: BYTE_W];
		end
	end

	// The smoothed state; a step never exceeds the distance, so no overshoot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_now_q <= '0;
			sat_now_q <= '0;
			val_now_q <= '0;
		end else begin
			if (cmd.upd_hue) begin
				hue_now_q <= sign_q ? hue_now_q - stp : hue_now_q + stp;
			end
			if (cmd.upd_sat) begin
				sat_now_q <= sign_q ? sat_now_q - stp : sat_now_q + stp;
			end
			if (cmd.upd_val) begin
				val_now_q <= sign_q ? val_now_q - stp : val_now_q + stp;
			end
		end
	end

	assign hue_out = hue_q;
	assign sat_out = sat_q;
	assign val_out = val_q;

endmodule

### hw/rtl/aqi_led_color_smoother.sv
// Air-quality status LED color smoother.
// The in_ch channel carries one word per tick: the air quality index and a
// night flag. For each accepted word the block returns exactly one word on
// out_ch with the smoothed hue, saturation and brightness of the LED.
// The index is clamped to 50..300 and bent by an easing curve into a hue
// target between the clean-air hue and the foul-air hue; all three channels
// then move a fraction smoothing_gain / 65536 of their remaining distance.
// From input acceptance to the valid result, each word goes through the
// bit-serial square root, six passes through the single shared multiplier,
// and the steps that load the root, finish the value update and load the
// output register. One word is worked on at a time, so a new input word is
// taken only after the previous one is loaded into the output register.
// The result sits in an output register; the next input word is accepted
// while it waits. If the receiver stalls for longer, the finished word of
// the following tick is held inside until the output register drains.
// Reset loads the register defaults and clears hue, saturation and value
// to zero. Configuration writes are meant for idle periods only.
module aqi_led_color_smoother (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [aqils_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aqils_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	aqils_in_if.sink                            in_ch,
	aqils_out_if.source                         out_ch
);
	import aqils_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	// Configuration registers. Writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clean_hue   <= RST_CLEAN_HUE;
			cfg_q.foul_hue    <= RST_FOUL_HUE;
			cfg_q.day_value   <= RST_DAY_VALUE;
			cfg_q.night_value <= RST_NIGHT_VAL;
			cfg_q.sat_target  <= RST_SAT_TARGET;
			cfg_q.gain        <= RST_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLEAN_HUE:  cfg_q.clean_hue   <= cfg_wdata;
				CFG_FOUL_HUE:   cfg_q.foul_hue    <= cfg_wdata;
				CFG_DAY_VALUE:  cfg_q.day_value   <= cfg_wdata[BYTE_W-1:0];
				CFG_NIGHT_VAL:  cfg_q.night_value <= cfg_wdata[BYTE_W-1:0];
				CFG_SAT_TARGET: cfg_q.sat_target  <= cfg_wdata[BYTE_W-1:0];
				CFG_GAIN:       cfg_q.gain        <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign stat.in_valid  = in_ch.valid;
	assign stat.out_ready = out_ch.ready;

	// The controller sequences the multiplier passes and the root steps.
	aqils_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid)
	);

	// The datapath holds the smoothed state, the multiplier and the root unit.
	aqils_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.air_index (in_ch.air_index),
		.night     (in_ch.night),
		.hue_out   (out_ch.hue_out),
		.sat_out   (out_ch.sat_out),
		.val_out   (out_ch.val_out)
	);

endmodule
